// ----- src/cfws_pkg.sv -----
// Shared types, codes and constants for the searchable circular FIFO.
`timescale 1ns / 1ps

package cfws_pkg;

  localparam int WORD_W        = 32;
  localparam int DEPTH_DEFAULT = 16;
  localparam int REQ_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int COUNT_OUT_W   = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [WORD_W-1:0] data_word;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     is_empty;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic signed [WORD_W-1:0] front_value;
    logic                     found;
    logic [COUNT_OUT_W-1:0]   match_position;
  } rsp_item_t;

endpackage

// ----- src/cfws_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module cfws_ram #(
  parameter int WIDTH = cfws_pkg::WORD_W,
  parameter int DEPTH = cfws_pkg::DEPTH_DEFAULT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/circular_fifo_with_search_top.sv -----
// Top level of the searchable circular FIFO: control, pointers and result register.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one request per item:
//   push a word, pop the oldest word, or search the stored words for a key.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one result per
//   request: status, empty flag, entry count, front word, and for a search
//   the found flag and the 1-based position of the first match.
//   Requests are handled one at a time; req_stall is low only while idle.
//   Push, an unused request code, and a pop or search of an empty queue go
//   from idle straight to done; other pops pass a read state first; other
//   searches scan, reading one stored entry per cycle from the entry RAM read
//   port, until a match or the last entry. The next request is accepted the
//   cycle after the result enters the output register, so a stalled receiver
//   holds at most one pending result plus one in the output register.
//   Reset (rst, synchronous) empties the queue and drops any pending result;
//   the entry RAM is not cleared, only pushed entries ever reach a result.
`timescale 1ns / 1ps

module circular_fifo_with_search_top #(
  parameter int DEPTH = cfws_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  cfws_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output cfws_pkg::rsp_item_t rsp
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  cfws_pkg::state_t state, state_next;

  logic [IDX_W-1:0]              front;
  logic [CNT_W-1:0]              count;
  logic [cfws_pkg::WORD_W-1:0]   front_val;
  logic [cfws_pkg::WORD_W-1:0]   key;
  logic [cfws_pkg::STATUS_W-1:0] status_q;
  logic                          found_q;
  logic [CNT_W-1:0]              pos_q;
  logic [IDX_W-1:0]              scan_addr;
  logic [CNT_W-1:0]              scan_pos;

  logic                          accept;
  logic                          rsp_load;
  logic                          full;
  logic                          scan_hit;
  logic                          scan_last;
  logic [SUM_W-1:0]              tail_sum;
  logic [IDX_W-1:0]              tail;
  logic [IDX_W-1:0]              front_inc;
  logic [IDX_W-1:0]              scan_inc;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [cfws_pkg::WORD_W-1:0]   ram_rdata;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = a + 1'b1;
    end
    return r;
  endfunction

  cfws_ram #(
    .WIDTH (cfws_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.data_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept    = req_valid && !req_stall;
  assign rsp_load  = (state == cfws_pkg::S_DONE) && (!rsp_valid || !rsp_stall);
  assign full      = (count == CNT_W'(DEPTH));
  assign tail_sum  = SUM_W'(front) + SUM_W'(count);
  assign tail      = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(tail_sum);
  assign front_inc = wrap_inc(front);
  assign scan_inc  = wrap_inc(scan_addr);
  assign scan_hit  = (ram_rdata == key);
  assign scan_last = (CNT_W'(scan_pos + 1'b1) == count);

  always_comb begin
    state_next = state;
    unique case (state)
      cfws_pkg::S_IDLE: begin
        if (accept) begin
          if (req.req_type == cfws_pkg::REQ_POP && count != '0) begin
            state_next = cfws_pkg::S_POP_RD;
          end else if (req.req_type == cfws_pkg::REQ_SEARCH && count != '0) begin
            state_next = cfws_pkg::S_SCAN;
          end else begin
            state_next = cfws_pkg::S_DONE;
          end
        end
      end
      cfws_pkg::S_POP_RD: begin
        state_next = cfws_pkg::S_DONE;
      end
      cfws_pkg::S_SCAN: begin
        if (scan_hit || scan_last) begin
          state_next = cfws_pkg::S_DONE;
        end
      end
      cfws_pkg::S_DONE: begin
        if (rsp_load) begin
          state_next = cfws_pkg::S_IDLE;
        end
      end
      default: state_next = cfws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_re    = 1'b0;
    ram_raddr = front;
    unique case (state)
      cfws_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          if (req.req_type == cfws_pkg::REQ_PUSH) begin
            ram_we = !full;
          end else if (req.req_type == cfws_pkg::REQ_POP) begin
            ram_re    = 1'b1;
            ram_raddr = front_inc;
          end else if (req.req_type == cfws_pkg::REQ_SEARCH) begin
            ram_re    = 1'b1;
            ram_raddr = front;
          end
        end
      end
      cfws_pkg::S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = scan_inc;
      end
      cfws_pkg::S_POP_RD,
      cfws_pkg::S_DONE: begin
        req_stall = 1'b1;
      end
      default: req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cfws_pkg::S_IDLE;
      front     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (req.req_type)
          cfws_pkg::REQ_PUSH: begin
            if (!full) begin
              count <= count + 1'b1;
            end
          end
          cfws_pkg::REQ_POP: begin
            if (count != '0) begin
              count <= count - 1'b1;
              front <= front_inc;
            end
          end
          default: ;
        endcase
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key       <= req.data_word;
      status_q  <= cfws_pkg::STATUS_DONE;
      found_q   <= 1'b0;
      pos_q     <= '0;
      scan_pos  <= '0;
      scan_addr <= front;
      if (req.req_type == cfws_pkg::REQ_PUSH) begin
        if (full) begin
          status_q <= cfws_pkg::STATUS_FULL;
        end else if (count == '0) begin
          front_val <= req.data_word;
        end
      end else if (req.req_type == cfws_pkg::REQ_POP && count == '0) begin
        status_q <= cfws_pkg::STATUS_EMPTY;
      end
    end
    if (state == cfws_pkg::S_POP_RD) begin
      front_val <= ram_rdata;
    end
    if (state == cfws_pkg::S_SCAN) begin
      if (scan_hit) begin
        found_q <= 1'b1;
        pos_q   <= scan_pos + 1'b1;
      end else begin
        scan_pos  <= scan_pos + 1'b1;
        scan_addr <= scan_inc;
      end
    end
    if (rsp_load) begin
      rsp.status         <= status_q;
      rsp.is_empty       <= (count == '0);
      rsp.entry_count    <= cfws_pkg::COUNT_OUT_W'(count);
      rsp.front_value    <= (count == '0) ? '0 : front_val;
      rsp.found          <= found_q;
      rsp.match_position <= cfws_pkg::COUNT_OUT_W'(pos_q);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != cfws_pkg::S_IDLE)
    else $error("request accepted without leaving idle");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == cfws_pkg::S_DONE)
    else $error("result raised outside done state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == cfws_pkg::S_SCAN |-> scan_pos < count)
    else $error("search walked past stored entries");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == cfws_pkg::REQ_PUSH && !full)
      |=> count == $past(count) + 1'b1)
    else $error("push did not advance entry count");
`endif

endmodule

// ----- bench/tb_circular_fifo_with_search_top.sv -----
// Self-checking bench for the searchable circular FIFO: directed and random requests.
`timescale 1ns / 1ps

module tb_circular_fifo_with_search_top;

  localparam int WORD_W = cfws_pkg::WORD_W;
  localparam int DEPTH_DEFAULT = cfws_pkg::DEPTH_DEFAULT;
  localparam int COUNT_OUT_W = cfws_pkg::COUNT_OUT_W;
  localparam logic [cfws_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_PCT = 19;
  localparam int DRAIN_CYCLES = 40;
  localparam int PTR_W = $clog2(DEPTH_DEFAULT);

  class queue_tracker;
    logic signed [WORD_W-1:0] words [DEPTH_DEFAULT];
    logic [PTR_W-1:0] front;
    logic [COUNT_OUT_W-1:0] count;
    cfws_pkg::rsp_item_t pending_results [$];
    int errors;

    function new();
      front = '0;
      count = '0;
      errors = 0;
    endfunction

    function cfws_pkg::rsp_item_t next_queue_result(cfws_pkg::req_item_t it);
      cfws_pkg::rsp_item_t r;
      int slot;
      r = '0;
      case (it.req_type)
        cfws_pkg::REQ_PUSH: begin
          if (count < DEPTH_DEFAULT) begin
            slot = (int'(front) + int'(count)) % DEPTH_DEFAULT;
            words[slot] = it.data_word;
            count = count + 1'b1;
          end else begin
            r.status = cfws_pkg::STATUS_FULL;
          end
        end
        cfws_pkg::REQ_POP: begin
          if (count != 0) begin
            count = count - 1'b1;
            front = PTR_W'((int'(front) + 1) % DEPTH_DEFAULT);
          end else begin
            r.status = cfws_pkg::STATUS_EMPTY;
          end
        end
        cfws_pkg::REQ_SEARCH: begin
          for (int i = 0; i < int'(count) && !r.found; i++) begin
            if (words[(int'(front) + i) % DEPTH_DEFAULT] === it.data_word) begin
              r.found = 1'b1;
              r.match_position = COUNT_OUT_W'(i + 1);
            end
          end
        end
        default: ;
      endcase
      r.is_empty = (count == 0);
      r.entry_count = count;
      if (count != 0) r.front_value = words[front];
      return r;
    endfunction

    function void note_request(cfws_pkg::req_item_t it);
      pending_results.push_back(next_queue_result(it));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 50) $display("%0t ns: %s", $time, what);
    endtask

    task compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (got !== want) report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    task check_result(cfws_pkg::rsp_item_t got);
      cfws_pkg::rsp_item_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", WORD_W'(want.status), WORD_W'(got.status));
      compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
      compare_field("entry_count", WORD_W'(want.entry_count), WORD_W'(got.entry_count));
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("found", WORD_W'(want.found), WORD_W'(got.found));
      compare_field("match_position", WORD_W'(want.match_position),
                    WORD_W'(got.match_position));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  cfws_pkg::req_item_t req;
  logic                rsp_valid;
  logic                rsp_stall;
  cfws_pkg::rsp_item_t rsp;
  logic                calm;

  queue_tracker tracker;

  circular_fifo_with_search_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) tracker.note_request(req);
    if (!rst && rsp_valid && !rsp_stall) tracker.check_result(rsp);
  end

  always @(posedge clk) begin
    rsp_stall <= !rst && !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return -1;
      3, 4, 5, 6: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input logic [cfws_pkg::REQ_W-1:0] kind,
                      input logic signed [WORD_W-1:0] word);
    cfws_pkg::req_item_t it;
    it.req_type = kind;
    it.data_word = word;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
  endtask

  initial begin
    logic [cfws_pkg::REQ_W-1:0] kind;
    int push_pct;
    int roll;
    tracker = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    calm = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send(cfws_pkg::REQ_SEARCH, 0);
    send(cfws_pkg::REQ_POP, 0);
    send(REQ_UNUSED, 0);
    send(cfws_pkg::REQ_PUSH, WORD_MIN);
    send(cfws_pkg::REQ_PUSH, WORD_MAX);
    send(cfws_pkg::REQ_PUSH, 0);
    send(cfws_pkg::REQ_PUSH, -1);
    send(cfws_pkg::REQ_PUSH, 1);
    send(cfws_pkg::REQ_SEARCH, -1);
    send(cfws_pkg::REQ_SEARCH, WORD_MIN);
    send(cfws_pkg::REQ_SEARCH, 32'h1234_5678);
    send(cfws_pkg::REQ_POP, 0);
    send(cfws_pkg::REQ_SEARCH, WORD_MIN);
    for (int i = 0; i < 12; i++) send(cfws_pkg::REQ_PUSH, (i == 5) ? -1 : i * 3 + 100);
    send(cfws_pkg::REQ_PUSH, 7);
    send(cfws_pkg::REQ_SEARCH, 133);
    send(cfws_pkg::REQ_SEARCH, 32'h0bad_f00d);
    send(REQ_UNUSED, WORD_MAX);
    send(cfws_pkg::REQ_POP, WORD_MAX);

    push_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) push_pct = $urandom_range(20, 85);
      calm = (n >= 900 && n < 1200);
      roll = $urandom_range(0, 99);
      if (roll < 3) kind = REQ_UNUSED;
      else if (roll < 28) kind = cfws_pkg::REQ_SEARCH;
      else if ($urandom_range(0, 99) < push_pct) kind = cfws_pkg::REQ_PUSH;
      else kind = cfws_pkg::REQ_POP;
      send(kind, pick_word());
    end
    req_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/cfws_pkg.sv
src/cfws_ram.sv
src/circular_fifo_with_search_top.sv
bench/tb_circular_fifo_with_search_top.sv
